FILE: src/ppc_pkg.sv
`timescale 1ns / 1ps

package ppc_pkg;

  // Screen coordinate width of the window origin and the mouse position.
  localparam int unsigned COORD_BITS = 16;

  // Configuration register widths.
  localparam int unsigned EYE_W   = 8;
  localparam int unsigned RANGE_W = 8;
  localparam int unsigned PR_W    = 6;

  // Signed offset from the eye centre, and its magnitude.
  localparam int unsigned DIFF_W = COORD_BITS + 2;
  localparam int unsigned MAG_W  = COORD_BITS + 1;

  // Squared length, its square root and the scaled products.
  localparam int unsigned SQ_W   = 2 * MAG_W + 1;
  localparam int unsigned RT_W   = (SQ_W + 1) / 2;
  localparam int unsigned PROD_W = MAG_W + RANGE_W;
  localparam int unsigned MUL_W  = MAG_W;

  // The scaled component never exceeds the move range.
  localparam int unsigned QUO_W = RANGE_W;

  // Iteration counters of the square root and divider units.
  localparam int unsigned SQRT_CNT_W = $clog2(RT_W);
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W);

  // Kept relative position and the result coordinate width.
  localparam int unsigned REL_W = 18;
  localparam int unsigned OUT_W = 10;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 4 * COORD_BITS;
  localparam int unsigned OUT_DATA_W = ((2 * OUT_W + 1 + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EYE_RADIUS   = 2'd0,
    CFG_MOVE_RANGE   = 2'd1,
    CFG_PUPIL_RADIUS = 2'd2
  } cfg_idx_e;

  localparam logic [EYE_W-1:0]   EYE_RADIUS_RST   = 8'd64;
  localparam logic [RANGE_W-1:0] MOVE_RANGE_RST   = 8'd45;
  localparam logic [PR_W-1:0]    PUPIL_RADIUS_RST = 6'd8;

endpackage

FILE: src/ppc_mul.sv
`timescale 1ns / 1ps

// Shared multiplier with a registered product; the product holds while idle.
module ppc_mul (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ppc_pkg::MUL_W-1:0]    a_i,
  input  logic [ppc_pkg::MUL_W-1:0]    b_i,
  output logic [2*ppc_pkg::MUL_W-1:0]  prod_o
);

  logic [2*ppc_pkg::MUL_W-1:0] prod_q;

  // Product register, loaded only when a multiplication is issued.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: src/ppc_sqrt.sv
`timescale 1ns / 1ps

// Bit-serial floor square root: one result bit per cycle, restoring form.
module ppc_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppc_pkg::SQ_W-1:0]   rad_i,
  output logic                       done_o,
  output logic [ppc_pkg::RT_W-1:0]   root_o
);

  localparam int unsigned VAL_W = 2 * ppc_pkg::RT_W;
  localparam int unsigned REM_W = ppc_pkg::RT_W + 3;

  logic                            busy_q;
  logic                            done_q;
  logic [ppc_pkg::SQRT_CNT_W-1:0]  cnt_q;
  logic [VAL_W-1:0]                val_q;
  logic [REM_W-1:0]                rem_q;
  logic [ppc_pkg::RT_W-1:0]        root_q;
  logic [REM_W-1:0]                rem_shift;
  logic [REM_W-1:0]                trial;
  logic                            take;

  // Bring down the next two bits and try the odd trial value.
  always_comb begin
    rem_shift = {rem_q[REM_W-3:0], val_q[VAL_W-1 -: 2]};
    trial     = REM_W'({root_q, 2'b01});
    take      = (rem_shift >= trial);
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ppc_pkg::SQRT_CNT_W'(ppc_pkg::RT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and root datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= VAL_W'(rad_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[VAL_W-3:0], 2'b00};
      rem_q  <= take ? (rem_shift - trial) : rem_shift;
      root_q <= {root_q[ppc_pkg::RT_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: src/ppc_div.sv
`timescale 1ns / 1ps

// Restoring divider producing one quotient bit per cycle. The caller
// guarantees that the quotient fits in QUO_W bits.
module ppc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppc_pkg::PROD_W-1:0]  dividend_i,
  input  logic [ppc_pkg::RT_W-1:0]    divisor_i,
  output logic                        done_o,
  output logic [ppc_pkg::QUO_W-1:0]   quo_o
);

  localparam int unsigned TRY_W = ppc_pkg::RT_W + 1;

  logic                           busy_q;
  logic                           done_q;
  logic [ppc_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [ppc_pkg::RT_W-1:0]       rem_q;
  logic [ppc_pkg::QUO_W-1:0]      lo_q;
  logic [TRY_W-1:0]               rem_shift;
  logic [TRY_W-1:0]               div_ext;
  logic [TRY_W-1:0]               rem_sub;
  logic                           take;

  // Shift in the next dividend bit and compare against the divisor.
  always_comb begin
    rem_shift = {rem_q, lo_q[ppc_pkg::QUO_W-1]};
    div_ext   = TRY_W'(divisor_i);
    take      = (rem_shift >= div_ext);
    rem_sub   = rem_shift - div_ext;
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ppc_pkg::DIV_CNT_W'(ppc_pkg::QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder, with the quotient bits filling the low register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= ppc_pkg::RT_W'(dividend_i[ppc_pkg::PROD_W-1:ppc_pkg::QUO_W]);
      lo_q  <= dividend_i[ppc_pkg::QUO_W-1:0];
    end else if (busy_q) begin
      rem_q <= take ? rem_sub[ppc_pkg::RT_W-1:0] : rem_shift[ppc_pkg::RT_W-1:0];
      lo_q  <= {lo_q[ppc_pkg::QUO_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = lo_q;

endmodule

FILE: src/pupil_position_clamp_unit.sv
`timescale 1ns / 1ps

// Pupil position clamp: for each window origin and mouse position the unit
// returns the pupil's top-left corner relative to the window, moving the
// pupil under the mouse while the mouse lies within move_range of the eye
// centre, and otherwise scaling the offset back onto that range (clamped set).
// An item whose mouse position relative to the window equals the last one
// reported gives no result; the first item after reset always does. Items
// are taken one at a time: a suppressed item leaves after the check state,
// one under the mouse after the range compare, and a scaled one after the
// 18-step bit-serial square root and the two 8-step divisions that follow
// it, all fed by one shared multiplier. A finished result waits in the
// output register, so the next item may be taken meanwhile. Configuration
// writes take effect at once and are meant to be made while the unit is idle.
module pupil_position_clamp_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // window_x, window_y, mouse_x, mouse_y (lowest bits first)
  input  logic [ppc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pupil_x, pupil_y, clamped, zero fill (lowest bits first)
  output logic [ppc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned CB = ppc_pkg::COORD_BITS;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DIFF  = 13'b0000000000010,
    S_CHECK = 13'b0000000000100,
    S_MYY   = 13'b0000000001000,
    S_MRR   = 13'b0000000010000,
    S_CMP   = 13'b0000000100000,
    S_SQRT  = 13'b0000001000000,
    S_MDX   = 13'b0000010000000,
    S_DSX   = 13'b0000100000000,
    S_DWX   = 13'b0001000000000,
    S_DSY   = 13'b0010000000000,
    S_DWY   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [ppc_pkg::EYE_W-1:0]   eye_radius_q;
  logic [ppc_pkg::RANGE_W-1:0] move_range_q;
  logic [ppc_pkg::PR_W-1:0]    pupil_radius_q;

  // Item registers.
  logic [CB-1:0]                win_x_q, win_y_q, mouse_x_q, mouse_y_q;
  logic [ppc_pkg::DIFF_W-1:0]   dx_q, dy_q;
  logic [ppc_pkg::REL_W-1:0]    rel_x_q, rel_y_q;
  logic [ppc_pkg::SQ_W-1:0]     sq_q;
  logic [ppc_pkg::RT_W-1:0]     len_q;
  logic [ppc_pkg::QUO_W-1:0]    qx_q, qy_q;
  logic                         clamp_q;

  // Kept state.
  logic [ppc_pkg::REL_W-1:0]    last_x_q, last_y_q;
  logic                         have_last_q;

  // Output register.
  logic                         out_valid_q;
  logic [ppc_pkg::OUT_W-1:0]    out_x_q, out_y_q;
  logic                         out_clamp_q;

  // Shared unit connections.
  logic                         mul_en;
  logic [ppc_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [2*ppc_pkg::MUL_W-1:0]  mul_p;
  logic                         sqrt_start, sqrt_done;
  logic [ppc_pkg::RT_W-1:0]     sqrt_root;
  logic                         div_start, div_done;
  logic [ppc_pkg::QUO_W-1:0]    div_quo;

  // Combinational helpers.
  logic [ppc_pkg::DIFF_W-1:0]   mx_ext, my_ext, wx_ext, wy_ext, er_ext, pr_ext;
  logic [ppc_pkg::MAG_W-1:0]    adx, ady, rg_ext;
  logic                         same_rel;
  logic                         below_range;
  logic [ppc_pkg::QUO_W-1:0]    quo_safe;
  logic [ppc_pkg::OUT_W-1:0]    qx_ext, qy_ext, sx, sy, px, py;
  logic                         out_load;

  // Transfer on the input side.
  assign s_axis_tready = (state_q == S_IDLE);

  // Offsets from the eye centre and the position relative to the window.
  always_comb begin
    mx_ext = ppc_pkg::DIFF_W'(mouse_x_q);
    my_ext = ppc_pkg::DIFF_W'(mouse_y_q);
    wx_ext = {{(ppc_pkg::DIFF_W-CB){win_x_q[CB-1]}}, win_x_q};
    wy_ext = {{(ppc_pkg::DIFF_W-CB){win_y_q[CB-1]}}, win_y_q};
    er_ext = ppc_pkg::DIFF_W'(eye_radius_q);
    pr_ext = ppc_pkg::DIFF_W'(pupil_radius_q);
    adx    = dx_q[ppc_pkg::DIFF_W-1] ? ppc_pkg::MAG_W'(-dx_q) : ppc_pkg::MAG_W'(dx_q);
    ady    = dy_q[ppc_pkg::DIFF_W-1] ? ppc_pkg::MAG_W'(-dy_q) : ppc_pkg::MAG_W'(dy_q);
    rg_ext = ppc_pkg::MAG_W'(move_range_q);
    same_rel = have_last_q && (rel_x_q == last_x_q) && (rel_y_q == last_y_q);
    below_range = (sq_q < ppc_pkg::SQ_W'(mul_p));
    // A zero length only arises with a zero range; the scaled offset is then zero.
    quo_safe = (len_q == '0) ? '0 : div_quo;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = adx;
    mul_b  = adx;
    unique case (state_q)
      S_CHECK: begin
        mul_a = adx;
        mul_b = adx;
      end
      S_MYY: begin
        mul_a = ady;
        mul_b = ady;
      end
      S_MRR: begin
        mul_a = rg_ext;
        mul_b = rg_ext;
      end
      S_MDX: begin
        mul_a = adx;
        mul_b = rg_ext;
      end
      S_DSX: begin
        mul_a = ady;
        mul_b = rg_ext;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (state_q == S_CMP) && !below_range;
  assign div_start  = (state_q == S_DSX) || (state_q == S_DSY);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_DIFF;
      S_DIFF:  state_d = S_CHECK;
      S_CHECK: state_d = same_rel ? S_IDLE : S_MYY;
      S_MYY:   state_d = S_MRR;
      S_MRR:   state_d = S_CMP;
      S_CMP:   state_d = below_range ? S_DONE : S_SQRT;
      S_SQRT:  if (sqrt_done) state_d = S_MDX;
      S_MDX:   state_d = S_DSX;
      S_DSX:   state_d = S_DWX;
      S_DWX:   if (div_done) state_d = S_DSY;
      S_DSY:   state_d = S_DWY;
      S_DWY:   if (div_done) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Final corner: when clamped, scaled offset plus eye radius minus pupil radius; else the relative position.
  always_comb begin
    qx_ext = ppc_pkg::OUT_W'(qx_q);
    qy_ext = ppc_pkg::OUT_W'(qy_q);
    sx = dx_q[ppc_pkg::DIFF_W-1] ? (-qx_ext) : qx_ext;
    sy = dy_q[ppc_pkg::DIFF_W-1] ? (-qy_ext) : qy_ext;
    if (clamp_q) begin
      px = sx + ppc_pkg::OUT_W'(eye_radius_q) - ppc_pkg::OUT_W'(pupil_radius_q);
      py = sy + ppc_pkg::OUT_W'(eye_radius_q) - ppc_pkg::OUT_W'(pupil_radius_q);
    end else begin
      px = rel_x_q[ppc_pkg::OUT_W-1:0];
      py = rel_y_q[ppc_pkg::OUT_W-1:0];
    end
    out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  end

  // Control state: sequencer, configuration, kept position and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      eye_radius_q   <= ppc_pkg::EYE_RADIUS_RST;
      move_range_q   <= ppc_pkg::MOVE_RANGE_RST;
      pupil_radius_q <= ppc_pkg::PUPIL_RADIUS_RST;
      last_x_q       <= '0;
      last_y_q       <= '0;
      have_last_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ppc_pkg::CFG_EYE_RADIUS:   eye_radius_q   <= cfg_data_i[ppc_pkg::EYE_W-1:0];
          ppc_pkg::CFG_MOVE_RANGE:   move_range_q   <= cfg_data_i[ppc_pkg::RANGE_W-1:0];
          ppc_pkg::CFG_PUPIL_RADIUS: pupil_radius_q <= cfg_data_i[ppc_pkg::PR_W-1:0];
          default: ;
        endcase
      end
      if ((state_q == S_CHECK) && !same_rel) begin
        last_x_q    <= rel_x_q;
        last_y_q    <= rel_y_q;
        have_last_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item datapath.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      win_x_q   <= s_axis_tdata[CB-1:0];
      win_y_q   <= s_axis_tdata[2*CB-1:CB];
      mouse_x_q <= s_axis_tdata[3*CB-1:2*CB];
      mouse_y_q <= s_axis_tdata[4*CB-1:3*CB];
    end
    if (state_q == S_DIFF) begin
      dx_q    <= mx_ext - wx_ext - er_ext;
      dy_q    <= my_ext - wy_ext - er_ext;
      rel_x_q <= ppc_pkg::REL_W'(mx_ext - wx_ext - pr_ext);
      rel_y_q <= ppc_pkg::REL_W'(my_ext - wy_ext - pr_ext);
    end
    if (state_q == S_MYY) begin
      sq_q <= ppc_pkg::SQ_W'(mul_p);
    end
    if (state_q == S_MRR) begin
      sq_q <= sq_q + ppc_pkg::SQ_W'(mul_p);
    end
    if (state_q == S_CMP) begin
      clamp_q <= !below_range;
    end
    if ((state_q == S_SQRT) && sqrt_done) begin
      len_q <= sqrt_root;
    end
    if ((state_q == S_DWX) && div_done) begin
      qx_q <= quo_safe;
    end
    if ((state_q == S_DWY) && div_done) begin
      qy_q <= quo_safe;
    end
    if (out_load) begin
      out_x_q     <= px;
      out_y_q     <= py;
      out_clamp_q <= clamp_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ppc_pkg::OUT_DATA_W'({out_clamp_q, out_y_q, out_x_q});

  ppc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  ppc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sq_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  ppc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ppc_pkg::PROD_W'(mul_p)),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

`ifndef SYNTH
  // The sequencer always sits in exactly one state.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state is not one-hot");

  // An accepted item is always followed by the offset stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == S_DIFF)
    else $error("accepted item did not enter the offset stage");

  // The square root only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == S_SQRT)
    else $error("square root finished outside its wait state");

  // A scaled component never exceeds the move range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done && (len_q != '0) |-> ppc_pkg::RANGE_W'(div_quo) <= move_range_q)
    else $error("scaled offset exceeds the move range");
`endif

endmodule
